### design/stun_rv_pkg.sv
// Shared types, constants and helper functions for the STUN request validator.
// Has no dependencies; every other design file imports it.
package stun_rv_pkg;

  // Largest packet that is parsed; later bytes only mark the packet as too long.
  localparam int unsigned MaxPacketBytes = 2048;
  localparam int unsigned PosW           = $clog2(MaxPacketBytes);
  localparam int unsigned CountW         = PosW + 1;
  localparam int unsigned HeaderBytes    = 20;
  localparam int unsigned OutW           = 56;

  // Attribute and message type codes.
  localparam logic [15:0] TypeBindingReq  = 16'h0001;
  localparam logic [15:0] AttrUsername    = 16'h0006;
  localparam logic [15:0] AttrIntegrity   = 16'h0008;
  localparam logic [15:0] AttrFingerprint = 16'h8028;

  // CRC-32 constants.
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] FpXorValue = 32'h5354_554E;

  // Verdict codes, first error wins in the order checked by the verdict logic.
  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_COOKIE      = 4'd2,
    ST_LENGTH      = 4'd3,
    ST_ATTR_HDR    = 4'd4,
    ST_OVERRUN     = 4'd5,
    ST_AFTER_FP    = 4'd6,
    ST_FP_LENGTH   = 4'd7,
    ST_FP_MISMATCH = 4'd8,
    ST_TOO_LONG    = 4'd9
  } status_t;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER   = 4'b0001,
    PH_ATTR_HDR = 4'b0010,
    PH_VALUE    = 4'b0100,
    PH_DONE     = 4'b1000
  } phase_t;

  // Control from the parser to the CRC unit.
  typedef struct packed {
    logic       upd;
    logic       clr;
    logic [7:0] data;
  } crc_ctl_t;

  // Packet summary after the current byte, handed to the verdict logic.
  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic              cookie_bad;
    logic [15:0]       declared_length;
    logic [15:0]       message_type;
    status_t           walk_error;
    logic              user_seen;
    logic [PosW-1:0]   user_off;
    logic [PosW-1:0]   user_len;
    logic              integ_seen;
    logic [PosW-1:0]   integ_off;
    logic [PosW-1:0]   integ_len;
    logic              fp_seen;
    logic              fp_len_ok;
    logic [31:0]       fp_crc;
    logic [31:0]       fp_value;
  } summary_t;

  // Result word as carried on out_tdata, lowest field last.
  typedef struct packed {
    logic [3:0]  pad;
    logic        fingerprint_present;
    logic [10:0] integrity_length;
    logic [10:0] integrity_offset;
    logic        integrity_present;
    logic [10:0] username_length;
    logic [10:0] username_offset;
    logic        username_present;
    logic        is_binding_request;
    status_t     status;
  } result_t;

  // Reflected CRC-32 over one byte, bit at a time.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Expected magic cookie byte at header offsets 4 to 7.
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0: v = 8'h21;
      2'd1: v = 8'h12;
      2'd2: v = 8'hA4;
      default: v = 8'h42;
    endcase
    return v;
  endfunction

endpackage

### design/stun_rv_crc.sv
// Running CRC-32 over the parsed bytes of the current packet.
// Depends on stun_rv_pkg for the CRC function and the control struct.
module stun_rv_crc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stun_rv_pkg::crc_ctl_t ctl,
  output logic [31:0]           crc
);
  import stun_rv_pkg::*;

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;

  // Clear at the end of a packet, otherwise fold in each parsed byte.
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clr) begin
      crc_nxt = CrcInit;
    end else if (ctl.upd) begin
      crc_nxt = crc_byte(crc_r, ctl.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CrcInit;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

### design/stun_rv_walk.sv
// Header check and attribute walk, one byte per step, with per-packet state.
// Depends on stun_rv_pkg; drives the CRC unit and feeds the verdict logic.
module stun_rv_walk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            data,
  input  logic                  last,
  input  logic [31:0]           crc,
  output stun_rv_pkg::crc_ctl_t crc_ctl,
  output stun_rv_pkg::summary_t summary
);
  import stun_rv_pkg::*;

  // Packet state.
  logic [CountW-1:0] byte_count_r,  byte_count_w,  byte_count_nxt;
  phase_t            phase_r,       phase_w,       phase_nxt;
  logic [15:0]       msg_type_r,    msg_type_w,    msg_type_nxt;
  logic [15:0]       decl_len_r,    decl_len_w,    decl_len_nxt;
  logic              cookie_bad_r,  cookie_bad_w,  cookie_bad_nxt;
  logic [15:0]       body_rem_r,    body_rem_w,    body_rem_nxt;
  logic [15:0]       attr_code_r,   attr_code_w,   attr_code_nxt;
  logic [15:0]       attr_rem_r,    attr_rem_w,    attr_rem_nxt;
  logic [1:0]        hdr_idx_r,     hdr_idx_w,     hdr_idx_nxt;
  logic [2:0]        val_idx_r,     val_idx_w,     val_idx_nxt;
  status_t           walk_err_r,    walk_err_w,    walk_err_nxt;
  logic [31:0]       crc_start_r,   crc_start_w,   crc_start_nxt;
  logic              user_seen_r,   user_seen_w,   user_seen_nxt;
  logic [PosW-1:0]   user_off_r,    user_off_w,    user_off_nxt;
  logic [PosW-1:0]   user_len_r,    user_len_w,    user_len_nxt;
  logic              integ_seen_r,  integ_seen_w,  integ_seen_nxt;
  logic [PosW-1:0]   integ_off_r,   integ_off_w,   integ_off_nxt;
  logic [PosW-1:0]   integ_len_r,   integ_len_w,   integ_len_nxt;
  logic              fp_seen_r,     fp_seen_w,     fp_seen_nxt;
  logic              fp_len_ok_r,   fp_len_ok_w,   fp_len_ok_nxt;
  logic [31:0]       fp_crc_r,      fp_crc_w,      fp_crc_nxt;
  logic [31:0]       fp_value_r,    fp_value_w,    fp_value_nxt;

  logic              in_range;
  logic [PosW-1:0]   pos;
  logic [16:0]       padded;
  logic [15:0]       body_m4;
  logic [15:0]       attr_len_w;

  assign in_range   = (byte_count_r < CountW'(MaxPacketBytes));
  assign pos        = byte_count_r[PosW-1:0];
  assign attr_len_w = {attr_rem_r[7:0], data};
  assign padded     = ({1'b0, attr_len_w} + 17'd3) & ~17'd3;
  assign body_m4    = body_rem_r - 16'd4;

  // Parse one byte: the walked state after this byte.
  always_comb begin
    byte_count_w = in_range ? byte_count_r + 1'b1 : CountW'(MaxPacketBytes + 1);
    phase_w      = phase_r;
    msg_type_w   = msg_type_r;
    decl_len_w   = decl_len_r;
    cookie_bad_w = cookie_bad_r;
    body_rem_w   = body_rem_r;
    attr_code_w  = attr_code_r;
    attr_rem_w   = attr_rem_r;
    hdr_idx_w    = hdr_idx_r;
    val_idx_w    = val_idx_r;
    walk_err_w   = walk_err_r;
    crc_start_w  = crc_start_r;
    user_seen_w  = user_seen_r;
    user_off_w   = user_off_r;
    user_len_w   = user_len_r;
    integ_seen_w = integ_seen_r;
    integ_off_w  = integ_off_r;
    integ_len_w  = integ_len_r;
    fp_seen_w    = fp_seen_r;
    fp_len_ok_w  = fp_len_ok_r;
    fp_crc_w     = fp_crc_r;
    fp_value_w   = fp_value_r;
    if (in_range) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos < PosW'(2)) begin
            msg_type_w = {msg_type_r[7:0], data};
          end else if (pos < PosW'(4)) begin
            decl_len_w = {decl_len_r[7:0], data};
          end else if (pos < PosW'(8) && data != cookie_byte(pos[1:0])) begin
            cookie_bad_w = 1'b1;
          end
          if (pos == PosW'(HeaderBytes - 1)) begin
            body_rem_w = decl_len_r;
            hdr_idx_w  = 2'd0;
            phase_w    = (decl_len_r != 16'd0) ? PH_ATTR_HDR : PH_DONE;
          end
        end
        PH_ATTR_HDR: begin
          if (hdr_idx_r == 2'd0 && !fp_seen_r) begin
            crc_start_w = crc;
          end
          if (hdr_idx_r == 2'd0 && body_rem_r < 16'd4) begin
            // Not even room for an attribute header.
            walk_err_w = ST_ATTR_HDR;
            phase_w    = PH_DONE;
          end else begin
            if (hdr_idx_r < 2'd2) begin
              attr_code_w = {attr_code_r[7:0], data};
            end else begin
              attr_rem_w = attr_len_w;
            end
            hdr_idx_w = hdr_idx_r + 2'd1;
            if (hdr_idx_r == 2'd3) begin
              body_rem_w = body_m4;
              if (padded > {1'b0, body_m4}) begin
                walk_err_w = ST_OVERRUN;
                phase_w    = PH_DONE;
              end else if (fp_seen_r) begin
                walk_err_w = ST_AFTER_FP;
                phase_w    = PH_DONE;
              end else begin
                // Note where the attributes of interest sit.
                if (attr_code_r == AttrUsername) begin
                  user_seen_w = 1'b1;
                  user_off_w  = pos + PosW'(1);
                  user_len_w  = padded[PosW-1:0];
                end else if (attr_code_r == AttrIntegrity) begin
                  integ_seen_w = 1'b1;
                  integ_off_w  = pos - PosW'(3);
                  integ_len_w  = padded[PosW-1:0];
                end else if (attr_code_r == AttrFingerprint) begin
                  fp_seen_w   = 1'b1;
                  fp_len_ok_w = (padded == 17'd4);
                  fp_crc_w    = crc_start_r;
                end
                attr_rem_w = padded[15:0];
                body_rem_w = body_m4 - padded[15:0];
                val_idx_w  = 3'd0;
                if (padded == 17'd0) begin
                  hdr_idx_w = 2'd0;
                  phase_w   = (body_m4 != 16'd0) ? PH_ATTR_HDR : PH_DONE;
                end else begin
                  phase_w = PH_VALUE;
                end
              end
            end
          end
        end
        PH_VALUE: begin
          // The fingerprint value is its first four bytes, big-endian.
          if (attr_code_r == AttrFingerprint && !val_idx_r[2]) begin
            fp_value_w = {fp_value_r[23:0], data};
          end
          if (!val_idx_r[2]) begin
            val_idx_w = val_idx_r + 3'd1;
          end
          attr_rem_w = attr_rem_r - 16'd1;
          if (attr_rem_r == 16'd1) begin
            hdr_idx_w = 2'd0;
            phase_w   = (body_rem_r != 16'd0) ? PH_ATTR_HDR : PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Commit a step; the last byte of a packet returns everything to reset.
  always_comb begin
    byte_count_nxt = byte_count_r;
    phase_nxt      = phase_r;
    msg_type_nxt   = msg_type_r;
    decl_len_nxt   = decl_len_r;
    cookie_bad_nxt = cookie_bad_r;
    body_rem_nxt   = body_rem_r;
    attr_code_nxt  = attr_code_r;
    attr_rem_nxt   = attr_rem_r;
    hdr_idx_nxt    = hdr_idx_r;
    val_idx_nxt    = val_idx_r;
    walk_err_nxt   = walk_err_r;
    crc_start_nxt  = crc_start_r;
    user_seen_nxt  = user_seen_r;
    user_off_nxt   = user_off_r;
    user_len_nxt   = user_len_r;
    integ_seen_nxt = integ_seen_r;
    integ_off_nxt  = integ_off_r;
    integ_len_nxt  = integ_len_r;
    fp_seen_nxt    = fp_seen_r;
    fp_len_ok_nxt  = fp_len_ok_r;
    fp_crc_nxt     = fp_crc_r;
    fp_value_nxt   = fp_value_r;
    if (fire && last) begin
      byte_count_nxt = '0;
      phase_nxt      = PH_HEADER;
      msg_type_nxt   = '0;
      decl_len_nxt   = '0;
      cookie_bad_nxt = 1'b0;
      body_rem_nxt   = '0;
      attr_code_nxt  = '0;
      attr_rem_nxt   = '0;
      hdr_idx_nxt    = '0;
      val_idx_nxt    = '0;
      walk_err_nxt   = ST_OK;
      crc_start_nxt  = '0;
      user_seen_nxt  = 1'b0;
      user_off_nxt   = '0;
      user_len_nxt   = '0;
      integ_seen_nxt = 1'b0;
      integ_off_nxt  = '0;
      integ_len_nxt  = '0;
      fp_seen_nxt    = 1'b0;
      fp_len_ok_nxt  = 1'b0;
      fp_crc_nxt     = '0;
      fp_value_nxt   = '0;
    end else if (fire) begin
      byte_count_nxt = byte_count_w;
      phase_nxt      = phase_w;
      msg_type_nxt   = msg_type_w;
      decl_len_nxt   = decl_len_w;
      cookie_bad_nxt = cookie_bad_w;
      body_rem_nxt   = body_rem_w;
      attr_code_nxt  = attr_code_w;
      attr_rem_nxt   = attr_rem_w;
      hdr_idx_nxt    = hdr_idx_w;
      val_idx_nxt    = val_idx_w;
      walk_err_nxt   = walk_err_w;
      crc_start_nxt  = crc_start_w;
      user_seen_nxt  = user_seen_w;
      user_off_nxt   = user_off_w;
      user_len_nxt   = user_len_w;
      integ_seen_nxt = integ_seen_w;
      integ_off_nxt  = integ_off_w;
      integ_len_nxt  = integ_len_w;
      fp_seen_nxt    = fp_seen_w;
      fp_len_ok_nxt  = fp_len_ok_w;
      fp_crc_nxt     = fp_crc_w;
      fp_value_nxt   = fp_value_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      phase_r      <= PH_HEADER;
      msg_type_r   <= '0;
      decl_len_r   <= '0;
      cookie_bad_r <= 1'b0;
      body_rem_r   <= '0;
      attr_code_r  <= '0;
      attr_rem_r   <= '0;
      hdr_idx_r    <= '0;
      val_idx_r    <= '0;
      walk_err_r   <= ST_OK;
      crc_start_r  <= '0;
      user_seen_r  <= 1'b0;
      user_off_r   <= '0;
      user_len_r   <= '0;
      integ_seen_r <= 1'b0;
      integ_off_r  <= '0;
      integ_len_r  <= '0;
      fp_seen_r    <= 1'b0;
      fp_len_ok_r  <= 1'b0;
      fp_crc_r     <= '0;
      fp_value_r   <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      phase_r      <= phase_nxt;
      msg_type_r   <= msg_type_nxt;
      decl_len_r   <= decl_len_nxt;
      cookie_bad_r <= cookie_bad_nxt;
      body_rem_r   <= body_rem_nxt;
      attr_code_r  <= attr_code_nxt;
      attr_rem_r   <= attr_rem_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      val_idx_r    <= val_idx_nxt;
      walk_err_r   <= walk_err_nxt;
      crc_start_r  <= crc_start_nxt;
      user_seen_r  <= user_seen_nxt;
      user_off_r   <= user_off_nxt;
      user_len_r   <= user_len_nxt;
      integ_seen_r <= integ_seen_nxt;
      integ_off_r  <= integ_off_nxt;
      integ_len_r  <= integ_len_nxt;
      fp_seen_r    <= fp_seen_nxt;
      fp_len_ok_r  <= fp_len_ok_nxt;
      fp_crc_r     <= fp_crc_nxt;
      fp_value_r   <= fp_value_nxt;
    end
  end

  // The CRC covers parsed bytes only and restarts with each packet.
  assign crc_ctl.upd  = fire && in_range;
  assign crc_ctl.clr  = fire && last;
  assign crc_ctl.data = data;

  // Packet state including the current byte, for the verdict.
  assign summary.byte_count      = byte_count_w;
  assign summary.cookie_bad      = cookie_bad_w;
  assign summary.declared_length = decl_len_w;
  assign summary.message_type    = msg_type_w;
  assign summary.walk_error      = walk_err_w;
  assign summary.user_seen       = user_seen_w;
  assign summary.user_off        = user_off_w;
  assign summary.user_len        = user_len_w;
  assign summary.integ_seen      = integ_seen_w;
  assign summary.integ_off       = integ_off_w;
  assign summary.integ_len       = integ_len_w;
  assign summary.fp_seen         = fp_seen_w;
  assign summary.fp_len_ok       = fp_len_ok_w;
  assign summary.fp_crc          = fp_crc_w;
  assign summary.fp_value        = fp_value_w;

endmodule

### design/stun_rv_verdict.sv
// Verdict logic: picks the first error in priority order and builds the result word.
// Depends on stun_rv_pkg for the summary and result types.
module stun_rv_verdict (
  input  stun_rv_pkg::summary_t summary,
  output stun_rv_pkg::result_t  result
);
  import stun_rv_pkg::*;

  status_t     status;
  logic [15:0] body_bytes;
  logic [31:0] fp_expect;

  assign body_bytes = {{(16 - CountW){1'b0}}, summary.byte_count} - 16'(HeaderBytes);
  assign fp_expect  = ~summary.fp_crc ^ FpXorValue;

  // Error priority: short, cookie, too long, length, walk, fingerprint checks.
  always_comb begin
    if (summary.byte_count < CountW'(HeaderBytes)) begin
      status = ST_SHORT;
    end else if (summary.cookie_bad) begin
      status = ST_COOKIE;
    end else if (summary.byte_count > CountW'(MaxPacketBytes)) begin
      status = ST_TOO_LONG;
    end else if (summary.declared_length != body_bytes) begin
      status = ST_LENGTH;
    end else if (summary.walk_error != ST_OK) begin
      status = summary.walk_error;
    end else if (summary.fp_seen && !summary.fp_len_ok) begin
      status = ST_FP_LENGTH;
    end else if (summary.fp_seen && fp_expect != summary.fp_value) begin
      status = ST_FP_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  // A failed packet reports the status alone.
  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.is_binding_request  = (summary.message_type == TypeBindingReq);
      result.username_present    = summary.user_seen;
      result.username_offset     = 11'(summary.user_off);
      result.username_length     = 11'(summary.user_len);
      result.integrity_present   = summary.integ_seen;
      result.integrity_offset    = 11'(summary.integ_off);
      result.integrity_length    = 11'(summary.integ_len);
      result.fingerprint_present = summary.fp_seen;
    end
  end

endmodule

### design/stun_request_validator_top.sv
// STUN request validator: takes one packet byte per word on in_* and gives one verdict
// word on out_* after the last byte. Built on stun_rv_pkg, crc, walk and verdict modules.
//
// The block accepts one byte per cycle unless held up (see below): each byte is captured
// in an input register and fully parsed from there, together with one step of the
// running CRC-32. The verdict is written to an output register, so a new packet can
// stream in while the verdict is still waiting. Only the last byte of a packet can be
// held up, and only while the previous verdict has not yet been taken. The verdict
// reports the first error (short, cookie, too long, length, attribute walk, fingerprint
// length, fingerprint mismatch) and, for a good packet, where the USERNAME and
// MESSAGE-INTEGRITY attributes sit. MESSAGE-INTEGRITY is located but not verified.
// Bytes beyond 2048 are not parsed and make the packet too long.
module stun_request_validator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] status, [4] is_binding_request, [5] username_present,
  // [16:6] username_offset, [27:17] username_length, [28] integrity_present,
  // [39:29] integrity_offset, [50:40] integrity_length, [51] fingerprint_present,
  // [55:52] zero
  output logic [55:0] out_tdata
);
  import stun_rv_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_vld_r;
  result_t    out_data_r;
  logic       out_free;
  logic       consume;
  logic [31:0] crc;
  crc_ctl_t   crc_ctl;
  summary_t   summary;
  result_t    result;

  // A last byte stays in the input register while the verdict slot is full and not taken.
  assign out_free  = !out_vld_r || out_tready;
  assign consume   = in_vld_r && (!in_last_r || out_free);
  assign in_tready = !in_vld_r || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  stun_rv_crc u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (crc_ctl),
    .crc  (crc)
  );

  stun_rv_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (consume),
    .data   (in_byte_r),
    .last   (in_last_r),
    .crc    (crc),
    .crc_ctl(crc_ctl),
    .summary(summary)
  );

  stun_rv_verdict u_verdict (
    .summary(summary),
    .result (result)
  );

  // Output register holding one verdict word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (consume && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last_r) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Every last byte that is parsed yields a verdict in the next cycle.
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_last_r |=> out_tvalid)
    else $error("last byte parsed without a verdict");

  // A last byte is never parsed while an untaken verdict would be overwritten.
  a_no_verdict_loss: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_last_r |-> !out_vld_r || out_tready)
    else $error("verdict overwritten before it was taken");

  // A failed packet carries no attribute information.
  a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != ST_OK |-> out_tdata[55:4] == '0)
    else $error("error verdict with nonzero fields");

  // The status is always one of the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= ST_TOO_LONG)
    else $error("undefined status code");

endmodule
